@@ hw/rtl/btnt_pkg.sv @@
// ----------------------------------------------------------------------------
// btnt_pkg
// Shared widths, reset constants and lane result type for the button tracker.
// ----------------------------------------------------------------------------
package btnt_pkg;

    localparam int FIELD_W = 16;
    localparam int TS_W    = 32;
    localparam int HOLD_W  = 31;

    localparam logic [HOLD_W-1:0] HOLD_TIME_RESET = 31'd2000000;

    // what one lane found for the current item
    typedef struct packed {
        logic pressed;
        logic changed;
        logic hold;
    } lane_result_t;

endpackage

@@ hw/rtl/btnt_lane.sv @@
// ----------------------------------------------------------------------------
// btnt_lane
// One button: last state, change time stamp and long-hold test.
// ----------------------------------------------------------------------------
module btnt_lane
    import btnt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                primed,
    input  logic                now_bit,
    input  logic [TS_W-1:0]     timestamp_us,
    input  logic [HOLD_W-1:0]   hold_time_us,
    output lane_result_t        result
);

    logic              last_bit_reg;
    logic              last_bit_next;
    logic [TS_W-1:0]   change_time_reg;
    logic [TS_W-1:0]   change_time_next;
    logic              changed;
    logic [TS_W-1:0]   elapsed;

    // before the first item the previous state counts as the complement
    assign changed = primed ? (now_bit ^ last_bit_reg) : 1'b1;

    assign elapsed = timestamp_us - change_time_reg;

    always_comb
    begin
        last_bit_next    = last_bit_reg;
        change_time_next = change_time_reg;
        if (fire)
        begin
            last_bit_next = now_bit;
            if (changed)
            begin
                change_time_next = timestamp_us;
            end
        end
    end

    // a freshly stamped button has zero elapsed time, so never long hold
    always_comb
    begin
        result.pressed = now_bit;
        result.changed = changed;
        result.hold    = now_bit && !changed && !elapsed[TS_W-1]
                         && (elapsed[HOLD_W-1:0] > hold_time_us);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_bit_reg <= 1'b0;
        end
        else
        begin
            last_bit_reg <= last_bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        change_time_reg <= change_time_next;
    end

endmodule

@@ hw/rtl/btnt_merge.sv @@
// ----------------------------------------------------------------------------
// btnt_merge
// Gathers the lane results into masks and holds them in the output register.
// ----------------------------------------------------------------------------
module btnt_merge
    import btnt_pkg::*;
#(
    parameter int LANES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lane_result_t        lane_res [LANES],
    input  logic                out_stall,
    output logic                out_valid,
    output logic [FIELD_W-1:0]  pressed_mask,
    output logic [FIELD_W-1:0]  changed_mask,
    output logic [FIELD_W-1:0]  press_edge_mask,
    output logic [FIELD_W-1:0]  release_edge_mask,
    output logic [FIELD_W-1:0]  long_hold_mask
);

    logic                valid_reg;
    logic                valid_next;
    logic [FIELD_W-1:0]  pressed_reg;
    logic [FIELD_W-1:0]  pressed_next;
    logic [FIELD_W-1:0]  changed_reg;
    logic [FIELD_W-1:0]  changed_next;
    logic [FIELD_W-1:0]  hold_reg;
    logic [FIELD_W-1:0]  hold_next;

    always_comb
    begin
        pressed_next = '0;
        changed_next = '0;
        hold_next    = '0;
        for (int i = 0; i < LANES; i++)
        begin
            pressed_next[i] = lane_res[i].pressed;
            changed_next[i] = lane_res[i].changed;
            hold_next[i]    = lane_res[i].hold;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pressed_reg <= pressed_next;
            changed_reg <= changed_next;
            hold_reg    <= hold_next;
        end
    end

    assign out_valid         = valid_reg;
    assign pressed_mask      = pressed_reg;
    assign changed_mask      = changed_reg;
    assign press_edge_mask   = pressed_reg & changed_reg;
    assign release_edge_mask = ~pressed_reg & changed_reg;
    assign long_hold_mask    = hold_reg;

endmodule

@@ hw/rtl/button_edge_and_long_hold_tracker.sv @@
// ----------------------------------------------------------------------------
// button_edge_and_long_hold_tracker
// Per-poll button edge masks and long-hold detection, one lane per button.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one poll: buttons and
//   timestamp_us. Output channel (out_valid / out_stall) carries one item of
//   five masks per poll. The config channel (cfg_valid / cfg_ready) writes
//   hold_time_us; cfg_ready is always high, write only while idle.
//   An accepted item is shown in the cycle after; throughput is one item per
//   cycle unless out_stall holds a result. Each lane does one 32-bit subtract
//   and 31-bit compare per item; the single output register sets the rate.
//   in_stall rises only when a result is held and the receiver stalls, so a
//   new item is taken in the same cycle the held result leaves.
//   Reset clears the output valid, the primed flag and sets hold_time_us to
//   2000000; the first poll after reset treats every button as changed.
//   Only min(NUM_BUTTONS, 16) lanes are built; buttons above that can never
//   see a press and read zero in every mask.
// ----------------------------------------------------------------------------
module button_edge_and_long_hold_tracker
    import btnt_pkg::*;
#(
    parameter int NUM_BUTTONS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FIELD_W-1:0]  buttons,
    input  logic [TS_W-1:0]     timestamp_us,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FIELD_W-1:0]  pressed_mask,
    output logic [FIELD_W-1:0]  changed_mask,
    output logic [FIELD_W-1:0]  press_edge_mask,
    output logic [FIELD_W-1:0]  release_edge_mask,
    output logic [FIELD_W-1:0]  long_hold_mask,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HOLD_W-1:0]   hold_time_us
);

    localparam int LANES = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;
    localparam logic [FIELD_W-1:0] LANE_MASK = FIELD_W'((64'd1 << LANES) - 64'd1);

    logic                fire;
    logic                primed_reg;
    logic                primed_next;
    logic [HOLD_W-1:0]   hold_time_reg;
    logic [HOLD_W-1:0]   hold_time_next;
    lane_result_t        lane_res [LANES];

    assign in_stall  = out_valid & out_stall;
    assign fire      = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        primed_next    = primed_reg | fire;
        hold_time_next = hold_time_reg;
        if (cfg_valid && cfg_ready)
        begin
            hold_time_next = hold_time_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            hold_time_reg <= HOLD_TIME_RESET;
        end
        else
        begin
            primed_reg    <= primed_next;
            hold_time_reg <= hold_time_next;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        btnt_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .fire         (fire),
            .primed       (primed_reg),
            .now_bit      (buttons[g]),
            .timestamp_us (timestamp_us),
            .hold_time_us (hold_time_reg),
            .result       (lane_res[g])
        );
    end

    btnt_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .lane_res          (lane_res),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .pressed_mask      (pressed_mask),
        .changed_mask      (changed_mask),
        .press_edge_mask   (press_edge_mask),
        .release_edge_mask (release_edge_mask),
        .long_hold_mask    (long_hold_mask)
    );

    // an accepted item always shows up at the output in the next cycle
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("accepted item did not reach the output");

    // the first item after reset reports every lane as changed
    a_first_all_changed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(primed_reg) |-> (out_valid && changed_mask == LANE_MASK))
        else $error("first item did not mark all buttons changed");

    // long hold needs a pressed button that did not change on this item
    a_hold_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((long_hold_mask & ~pressed_mask) == '0
                       && (long_hold_mask & changed_mask) == '0))
        else $error("long hold on a released or changed button");

    // no mask bit outside the built lanes
    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((pressed_mask | changed_mask | long_hold_mask)
                        & ~LANE_MASK) == '0))
        else $error("mask bit set above the lane count");

endmodule
